[sv/request_slot_table_round_robin_top_defines.svh]
// Assertion macros shared by the request slot table RTL.
// Included by the top level; expects clk and rst in scope.
`ifndef REQUEST_SLOT_TABLE_ROUND_ROBIN_TOP_DEFINES_SVH
`define REQUEST_SLOT_TABLE_ROUND_ROBIN_TOP_DEFINES_SVH

// Condition a implies condition c in the same cycle
`define RSTRR_ASSERT_SAME(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("rstrr check failed");

// Condition a implies condition c in the following cycle
`define RSTRR_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("rstrr check failed");

`endif

[sv/rstrr_pkg.sv]
// Package for the request slot table: operation and status codes,
// default sizes and the controller command word. No dependencies.
package rstrr_pkg;

  // Default table sizes
  localparam int SLOTS_DEF    = 16;
  localparam int TAG_BITS_DEF = 16;

  // Fixed port field widths
  localparam int FUNC_W   = 2;
  localparam int REQ_W    = 16;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int PTAG_W   = 16;
  localparam int LIVE_W   = 5;
  localparam int OUT_DATA_W = 32;

  // Operation codes; the unused code falls to the default arm (no operation)
  typedef enum logic [FUNC_W-1:0] {
    FUNC_STORE  = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_PICK   = 2'd2
  } func_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming word and its candidate vector
    logic commit;   // encode, update the table, load the output register
  } cmd_t;

endpackage

[sv/rstrr_ctrl.sv]
// Controller for the request slot table: two-state sequencer and the
// output valid flag. Depends on rstrr_pkg.
module rstrr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output rstrr_pkg::cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_COMMIT = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // Handshake and commands
  assign s_tready    = (state == S_IDLE);
  assign out_free    = !m_tvalid || m_tready;
  assign cmd.capture = s_tvalid && s_tready;
  assign cmd.commit  = (state == S_COMMIT) && out_free;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.capture) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (cmd.commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[sv/rstrr_dpath.sv]
// Datapath for the request slot table: slot valid bits, tag cells,
// candidate search, round robin pointer and output word. Depends on rstrr_pkg.
module rstrr_dpath #(
  parameter int SLOTS    = rstrr_pkg::SLOTS_DEF,
  parameter int TAG_BITS = rstrr_pkg::TAG_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rstrr_pkg::cmd_t                   cmd,
  input  logic [rstrr_pkg::FUNC_W-1:0]      func,
  input  logic [rstrr_pkg::REQ_W-1:0]       request_tag,
  output logic [rstrr_pkg::STATUS_W-1:0]    status,
  output logic [rstrr_pkg::SLOT_W-1:0]      slot_index,
  output logic [rstrr_pkg::PTAG_W-1:0]      picked_tag,
  output logic [rstrr_pkg::LIVE_W-1:0]      live_count
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int TIN_W = (TAG_BITS < rstrr_pkg::REQ_W) ? TAG_BITS : rstrr_pkg::REQ_W;
  localparam int TOUT_W = (TAG_BITS < rstrr_pkg::PTAG_W) ? TAG_BITS : rstrr_pkg::PTAG_W;
  localparam int SOUT_W = (IDX_W < rstrr_pkg::SLOT_W) ? IDX_W : rstrr_pkg::SLOT_W;
  localparam int COUT_W = (CNT_W < rstrr_pkg::LIVE_W) ? CNT_W : rstrr_pkg::LIVE_W;
  localparam logic [IDX_W:0] SLOTS_W  = (IDX_W + 1)'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // Table state
  logic [SLOTS-1:0]    valid;
  logic [TAG_BITS-1:0] tags [SLOTS];
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    last_picked;

  // Captured request
  rstrr_pkg::func_t    op;
  logic [TAG_BITS-1:0] tag;
  logic [IDX_W-1:0]    base;
  logic [SLOTS-1:0]    cand;

  // Accept-side logic
  logic [TAG_BITS-1:0]  tag_in;
  logic [IDX_W-1:0]     base_in;
  logic [2*SLOTS-1:0]   valid_pair;
  logic [SLOTS-1:0]     match;
  logic [SLOTS-1:0]     cand_in;

  // Commit-side logic
  logic                        found;
  logic [IDX_W-1:0]            first;
  logic [IDX_W:0]              pos_sum;
  logic [IDX_W-1:0]            pos;
  logic [IDX_W-1:0]            slot_sel;
  logic [TAG_BITS-1:0]         tag_sel;
  logic [CNT_W-1:0]            count_next;
  rstrr_pkg::status_t          status_next;
  logic                        slot_ok;
  logic                        tag_ok;

  // Input tag trimmed or widened to the stored width
  always_comb begin
    tag_in = '0;
    tag_in[TIN_W-1:0] = request_tag[TIN_W-1:0];
  end

  // Round robin start one past the last picked slot
  assign base_in    = (last_picked == LAST_IDX) ? '0 : last_picked + 1'b1;
  assign valid_pair = {valid, valid} >> base_in;

  // Per-slot tag compare
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = valid[i] && (tags[i] == tag_in);
    end
  end

  // Candidate vector per operation
  always_comb begin
    case (rstrr_pkg::func_t'(func))
      rstrr_pkg::FUNC_STORE:  cand_in = ~valid;
      rstrr_pkg::FUNC_REMOVE: cand_in = match;
      rstrr_pkg::FUNC_PICK:   cand_in = valid_pair[SLOTS-1:0];
      default:                cand_in = '0;
    endcase
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op   <= rstrr_pkg::func_t'(func);
      tag  <= tag_in;
      base <= base_in;
      cand <= cand_in;
    end
  end

  // Lowest set candidate
  always_comb begin
    first = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (cand[i]) first = IDX_W'(i);
    end
  end
  assign found = |cand;

  // Rotated position back to a slot number
  assign pos_sum  = {1'b0, base} + {1'b0, first};
  assign pos      = (pos_sum >= SLOTS_W) ? IDX_W'(pos_sum - SLOTS_W) : pos_sum[IDX_W-1:0];
  assign slot_sel = (op == rstrr_pkg::FUNC_PICK) ? pos : first;
  assign tag_sel  = tags[slot_sel];

  // Result and count per operation
  always_comb begin
    count_next  = count;
    status_next = rstrr_pkg::ST_OK;
    slot_ok     = 1'b0;
    tag_ok      = 1'b0;
    case (op)
      rstrr_pkg::FUNC_STORE: begin
        if (found) begin
          count_next = count + 1'b1;
          slot_ok    = 1'b1;
        end else begin
          status_next = rstrr_pkg::ST_FULL;
        end
      end
      rstrr_pkg::FUNC_REMOVE: begin
        if (found) begin
          count_next = count - 1'b1;
          slot_ok    = 1'b1;
        end else begin
          status_next = rstrr_pkg::ST_NOT_FOUND;
        end
      end
      rstrr_pkg::FUNC_PICK: begin
        if (found) begin
          slot_ok = 1'b1;
          tag_ok  = 1'b1;
        end else begin
          status_next = rstrr_pkg::ST_EMPTY;
        end
      end
      default: ;
    endcase
  end

  // Table control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      count       <= '0;
      last_picked <= '0;
    end else if (cmd.commit && found) begin
      case (op)
        rstrr_pkg::FUNC_STORE:  valid[first] <= 1'b1;
        rstrr_pkg::FUNC_REMOVE: valid[first] <= 1'b0;
        rstrr_pkg::FUNC_PICK:   last_picked  <= pos;
        default: ;
      endcase
      count <= count_next;
    end
  end

  // Tag cells, written on store
  always_ff @(posedge clk) begin
    if (cmd.commit && found && (op == rstrr_pkg::FUNC_STORE)) begin
      tags[first] <= tag;
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status     <= status_next;
      slot_index <= '0;
      picked_tag <= '0;
      live_count <= '0;
      if (slot_ok) slot_index[SOUT_W-1:0] <= slot_sel[SOUT_W-1:0];
      if (tag_ok)  picked_tag[TOUT_W-1:0] <= tag_sel[TOUT_W-1:0];
      live_count[COUT_W-1:0] <= count_next[COUT_W-1:0];
    end
  end

endmodule

[sv/request_slot_table_round_robin_top.sv]
// Request slot table, round robin pick: top level joining controller and
// datapath. Each accepted word is first captured and its candidate vector formed
// (free slots, tag matches or the valid bits rotated to the round robin start);
// a commit step then encodes the lowest candidate, updates the table and loads
// the output register. A new word is taken as soon as the block
// is back in idle, while the previous result may still wait in the output
// register; a result held on m_tready holds the commit stage. Reset clears
// all slots at once, with no clearing pass. Operations: store, remove, pick.
`include "request_slot_table_round_robin_top_defines.svh"

module request_slot_table_round_robin_top #(
  parameter int SLOTS    = rstrr_pkg::SLOTS_DEF,
  parameter int TAG_BITS = rstrr_pkg::TAG_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [rstrr_pkg::REQ_W-1:0]         s_tdata,   // [15:0] request_tag
  input  logic [rstrr_pkg::FUNC_W-1:0]        s_tuser,   // [1:0] func
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [rstrr_pkg::OUT_DATA_W-1:0]    m_tdata,   // [3:0] slot_index,
                                                          // [19:4] picked_tag,
                                                          // [24:20] live_count
  output logic [rstrr_pkg::STATUS_W-1:0]      m_tuser    // [1:0] status
);

  rstrr_pkg::cmd_t                  cmd;
  logic [rstrr_pkg::SLOT_W-1:0]     slot_index;
  logic [rstrr_pkg::PTAG_W-1:0]     picked_tag;
  logic [rstrr_pkg::LIVE_W-1:0]     live_count;

  // Sequencer
  rstrr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // Table and search
  rstrr_dpath #(
    .SLOTS    (SLOTS),
    .TAG_BITS (TAG_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .func        (s_tuser),
    .request_tag (s_tdata),
    .status      (m_tuser),
    .slot_index  (slot_index),
    .picked_tag  (picked_tag),
    .live_count  (live_count)
  );

  // Output word packing, zero filled to 32 bits
  assign m_tdata = {7'b0, live_count, picked_tag, slot_index};

  // An accepted word makes the block busy next cycle
  `RSTRR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // A commit never overwrites a result still held by the sink
  `RSTRR_ASSERT_SAME(a_commit_output_free, cmd.commit, !(m_tvalid && !m_tready))
  // Every commit presents a result word
  `RSTRR_ASSERT_NEXT(a_commit_shows_result, cmd.commit, m_tvalid)

endmodule

[tb/request_slot_table_checker.sv]
// Checker for the request slot table: watches both stream channels, keeps its
// own copy of the slot table, and compares every result word with the oldest
// reply the table copy produced. Depends on rstrr_pkg.
module request_slot_table_checker #(
  parameter int SLOTS    = rstrr_pkg::SLOTS_DEF,
  parameter int TAG_BITS = rstrr_pkg::TAG_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [rstrr_pkg::REQ_W-1:0]      s_tdata,   // [15:0] request_tag
  input  logic [rstrr_pkg::FUNC_W-1:0]     s_tuser,   // [1:0] func
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [rstrr_pkg::OUT_DATA_W-1:0] m_tdata,   // [3:0] slot_index,
                                                      // [19:4] picked_tag,
                                                      // [24:20] live_count
  input  logic [rstrr_pkg::STATUS_W-1:0]   m_tuser,   // [1:0] status
  output int                               fail_count,
  output int                               pending,
  output int                               words_checked,
  output int                               full_seen,
  output int                               not_found_seen,
  output int                               empty_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LINES = 40;

  typedef struct packed {
    rstrr_pkg::status_t           status;
    logic [rstrr_pkg::SLOT_W-1:0] slot;
    logic [rstrr_pkg::PTAG_W-1:0] tag;
    logic [rstrr_pkg::LIVE_W-1:0] live;
  } slot_reply_t;

  // Local copy of the table
  bit                  occ[SLOTS];
  logic [TAG_BITS-1:0] tags[SLOTS];
  int                  live_slots;
  int                  last_pick;

  slot_reply_t reply_q[$];

  initial begin
    fail_count     = 0;
    pending        = 0;
    words_checked  = 0;
    full_seen      = 0;
    not_found_seen = 0;
    empty_seen     = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_count < MAX_LINES) begin
      $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    end
    fail_count++;
  endtask

  // Apply one operation to the table copy and return the reply it yields
  function automatic slot_reply_t run_slot_op(input logic [rstrr_pkg::FUNC_W-1:0] op,
                                              input logic [rstrr_pkg::REQ_W-1:0]  tag_in);
    slot_reply_t         r;
    logic [TAG_BITS-1:0] tag;
    bit                  hit;
    int                  pos;
    r      = '0;
    r.status = rstrr_pkg::ST_OK;
    tag    = tag_in[TAG_BITS-1:0];
    hit    = 1'b0;
    case (op)
      rstrr_pkg::FUNC_STORE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!hit && !occ[i]) begin
            hit     = 1'b1;
            occ[i]  = 1'b1;
            tags[i] = tag;
            live_slots++;
            r.slot  = i[rstrr_pkg::SLOT_W-1:0];
          end
        end
        if (!hit) r.status = rstrr_pkg::ST_FULL;
      end
      rstrr_pkg::FUNC_REMOVE: begin
        // free slots never match, whatever tag they last held
        for (int i = 0; i < SLOTS; i++) begin
          if (!hit && occ[i] && tags[i] == tag) begin
            hit    = 1'b1;
            occ[i] = 1'b0;
            if (live_slots > 0) live_slots--;
            r.slot = i[rstrr_pkg::SLOT_W-1:0];
          end
        end
        if (!hit) r.status = rstrr_pkg::ST_NOT_FOUND;
      end
      rstrr_pkg::FUNC_PICK: begin
        // round robin from one past the last picked slot, wrapping
        pos = last_pick % SLOTS;
        for (int n = 0; n < SLOTS; n++) begin
          pos = (pos + 1) % SLOTS;
          if (!hit && occ[pos]) begin
            hit       = 1'b1;
            last_pick = pos;
            r.slot    = pos[rstrr_pkg::SLOT_W-1:0];
            r.tag     = rstrr_pkg::PTAG_W'(tags[pos]);
          end
        end
        if (!hit) r.status = rstrr_pkg::ST_EMPTY;
      end
      default: begin
        // unused code: no operation
      end
    endcase
    r.live = live_slots[rstrr_pkg::LIVE_W-1:0];
    return r;
  endfunction

  // Sample both channels at the clock edge
  always @(posedge clk) begin
    slot_reply_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        occ[i]  = 1'b0;
        tags[i] = '0;
      end
      live_slots = 0;
      last_pick  = 0;
      reply_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        reply_q.push_back(run_slot_op(s_tuser, s_tdata));
      end
      if (m_tvalid && m_tready) begin
        if (reply_q.size() == 0) begin
          report_mismatch("result word with nothing pending", m_tdata, 0);
        end else begin
          want = reply_q.pop_front();
          words_checked++;
          case (want.status)
            rstrr_pkg::ST_FULL:      full_seen++;
            rstrr_pkg::ST_NOT_FOUND: not_found_seen++;
            rstrr_pkg::ST_EMPTY:     empty_seen++;
            default:                 ;
          endcase
          if (m_tuser !== want.status) report_mismatch("status", m_tuser, want.status);
          if (m_tdata[3:0] !== want.slot) report_mismatch("slot_index", m_tdata[3:0], want.slot);
          if (m_tdata[19:4] !== want.tag) report_mismatch("picked_tag", m_tdata[19:4], want.tag);
          if (m_tdata[24:20] !== want.live) report_mismatch("live_count", m_tdata[24:20], want.live);
          if (m_tdata[31:25] !== 7'd0) report_mismatch("tdata pad bits", m_tdata[31:25], 0);
        end
      end
    end
    pending <= reply_q.size();
  end

endmodule

[tb/tb_request_slot_table_round_robin_top.sv]
// Testbench top for the request slot table: clock, reset, stimulus and the
// verdict. Depends on rstrr_pkg, the block's top level and the checker.
module tb_request_slot_table_round_robin_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rstrr_pkg::FUNC_W-1:0] FUNC_NOP = 2'd3;  // unused code
  localparam int RAND_WORDS = 2000;
  localparam int QUIET_TAIL = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAG_POOL = 10;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [rstrr_pkg::REQ_W-1:0]      s_tdata = '0;
  logic [rstrr_pkg::FUNC_W-1:0]     s_tuser = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [rstrr_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [rstrr_pkg::STATUS_W-1:0]   m_tuser;

  int fail_count, pending, words_checked, full_seen, not_found_seen, empty_seen;
  int words_sent = 0;
  int cycles = 0;
  int gap_odds = 0;    // sender gap: one chance in gap_odds per word, 0 = none
  int sink_odds = 0;   // receiver stall: one chance in sink_odds per cycle
  int hold_cnt = 0;
  logic [rstrr_pkg::REQ_W-1:0] tag_pool[TAG_POOL];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  request_slot_table_round_robin_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  request_slot_table_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .fail_count     (fail_count),
    .pending        (pending),
    .words_checked  (words_checked),
    .full_seen      (full_seen),
    .not_found_seen (not_found_seen),
    .empty_seen     (empty_seen)
  );

  // Receiver stalls: bursts of random length
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (sink_odds != 0 && $urandom_range(1, sink_odds) == 1) begin
      m_tready <= 1'b0;
      hold_cnt <= $urandom_range(0, 10);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one word and hold it until accepted; maybe idle afterwards
  task automatic send_word(input logic [rstrr_pkg::FUNC_W-1:0] op,
                           input logic [rstrr_pkg::REQ_W-1:0]  tag);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= tag;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Stop sending until every result word is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [rstrr_pkg::REQ_W-1:0] pick_tag();
    if ($urandom_range(0, 3) != 0) return tag_pool[$urandom_range(0, TAG_POOL - 1)];
    return rstrr_pkg::REQ_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    int mix;
    int roll;
    int lvl;
    logic [rstrr_pkg::FUNC_W-1:0] op;
    logic [rstrr_pkg::REQ_W-1:0] tag;

    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < TAG_POOL; i++) begin
      tag_pool[i] = rstrr_pkg::REQ_W'($urandom_range(0, 65535));
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, unused code, extreme tags, duplicates, stale tags
    sink_odds = 4;
    gap_odds  = 3;
    send_word(rstrr_pkg::FUNC_PICK, 16'h1234);     // pick on empty table
    send_word(FUNC_NOP, 16'hFFFF);                 // unused code
    send_word(rstrr_pkg::FUNC_STORE, 16'hFFFF);    // slot 0
    send_word(rstrr_pkg::FUNC_STORE, 16'h0000);    // slot 1
    send_word(rstrr_pkg::FUNC_STORE, 16'hFFFF);    // slot 2, duplicate tag
    send_word(rstrr_pkg::FUNC_REMOVE, 16'hFFFF);   // lowest match: slot 0
    send_word(rstrr_pkg::FUNC_REMOVE, 16'hFFFF);   // slot 2
    send_word(rstrr_pkg::FUNC_REMOVE, 16'hFFFF);   // only freed slots hold it now: not found
    send_word(rstrr_pkg::FUNC_PICK, 16'h0000);     // one past slot 0 lands on slot 1
    for (int i = 0; i < 15; i++) begin
      send_word(rstrr_pkg::FUNC_STORE, 16'hA5A5 ^ rstrr_pkg::REQ_W'(16'h1111 * i));
    end
    send_word(rstrr_pkg::FUNC_STORE, 16'h5A5A);    // table full
    drain_results();

    // Random: phases that lean toward filling, draining or neither
    mix = 2;
    for (int k = 0; k < RAND_WORDS; k++) begin
      if (k % 100 == 0) mix = $urandom_range(0, 2);
      if (k % 250 == 0) begin
        lvl = (k >= RAND_WORDS - QUIET_TAIL) ? 0 : $urandom_range(0, 2);
        case (lvl)
          0: begin gap_odds = 0; sink_odds = 0; end
          1: begin gap_odds = 8; sink_odds = 10; end
          default: begin gap_odds = 3; sink_odds = 3; end
        endcase
      end
      if (k >= RAND_WORDS - QUIET_TAIL) begin
        gap_odds  = 0;
        sink_odds = 0;
      end
      if (k == 700 || k == 1400) drain_results();

      roll = $urandom_range(0, 99);
      case (mix)
        0:       op = (roll < 55) ? rstrr_pkg::FUNC_STORE :
                      (roll < 75) ? rstrr_pkg::FUNC_REMOVE :
                      (roll < 95) ? rstrr_pkg::FUNC_PICK : FUNC_NOP;
        1:       op = (roll < 20) ? rstrr_pkg::FUNC_STORE :
                      (roll < 70) ? rstrr_pkg::FUNC_REMOVE :
                      (roll < 95) ? rstrr_pkg::FUNC_PICK : FUNC_NOP;
        default: op = (roll < 38) ? rstrr_pkg::FUNC_STORE :
                      (roll < 70) ? rstrr_pkg::FUNC_REMOVE :
                      (roll < 95) ? rstrr_pkg::FUNC_PICK : FUNC_NOP;
      endcase
      if (op == rstrr_pkg::FUNC_STORE || op == rstrr_pkg::FUNC_REMOVE) tag = pick_tag();
      else tag = rstrr_pkg::REQ_W'($urandom_range(0, 65535));
      send_word(op, tag);
    end

    // Wind down
    drain_results();
    repeat (8) @(posedge clk);
    $display("covered %0d words, %0d result words checked", words_sent, words_checked);
    $display("table full %0d, tag not found %0d, empty picks %0d",
             full_seen, not_found_seen, empty_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/rstrr_pkg.sv
sv/rstrr_ctrl.sv
sv/rstrr_dpath.sv
sv/request_slot_table_round_robin_top.sv
tb/request_slot_table_checker.sv
tb/tb_request_slot_table_round_robin_top.sv
